[sv/prwc_pkg.sv]
// ----------------------------------------------------------------------------
// PPU register write capture: shared package
// Event codes, address decode constants and widths used by the capture
// block, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package prwc_pkg;

  // Payload widths.
  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 8;
  localparam int unsigned EventW = 3;

  // Default depth of the VRAM write queue before a flush.
  localparam int unsigned QueueEntriesDef = 32;

  // Kind of result produced for a bus write.
  typedef enum logic [EventW-1:0] {
    EV_RAM    = 3'd0,
    EV_CTRL   = 3'd1,
    EV_MASK   = 3'd2,
    EV_SCROLL = 3'd3,
    EV_VRAM   = 3'd4,
    EV_IO     = 3'd5,
    EV_DEBUG  = 3'd6
  } event_t;

  // PPU register offsets within the eight-byte register window.
  typedef enum logic [2:0] {
    REG_CTRL   = 3'd0,
    REG_MASK   = 3'd1,
    REG_STATUS = 3'd2,
    REG_OAMADR = 3'd3,
    REG_OAMDAT = 3'd4,
    REG_SCROLL = 3'd5,
    REG_ADDR   = 3'd6,
    REG_DATA   = 3'd7
  } ppu_reg_t;

  // Address decode constants.
  localparam logic [AddrW-1:0] RamMask     = 16'h07FF;
  localparam logic [AddrW-4:0] PpuRegBase  = 13'h0400;  // 0x2000 >> 3
  localparam logic [AddrW-1:0] DmaAddr     = 16'h4014;
  localparam logic [AddrW-1:0] DebugBase   = 16'h0010;
  localparam logic [DataW-1:0] CtrlForce   = 8'h80;
  localparam logic [AddrW-1:0] StepWide    = 16'd32;
  localparam logic [AddrW-1:0] StepNarrow  = 16'd1;
  localparam int unsigned      CtrlIncBit  = 2;

endpackage

[sv/prwc_if.sv]
// ----------------------------------------------------------------------------
// PPU register write capture: channel interfaces
// Valid/ready channels for incoming bus writes and for decoded results.
// ----------------------------------------------------------------------------
interface prwc_in_if;
  import prwc_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] bus_address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output bus_address, output write_data, input ready);
  modport sink   (input valid, input bus_address, input write_data, output ready);
endinterface

interface prwc_out_if;
  import prwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [AddrW-1:0]  target;
  logic [DataW-1:0]  data_out;
  logic [DataW-1:0]  scroll_x;
  logic [DataW-1:0]  scroll_y;
  logic              flush_after;

  modport source (output valid, output event_res, output target, output data_out,
                  output scroll_x, output scroll_y, output flush_after, input ready);
  modport sink   (input valid, input event_res, input target, input data_out,
                  input scroll_x, input scroll_y, input flush_after, output ready);
endinterface

[sv/ppu_register_write_capture_top.sv]
// Requests pass the input register, then the output register; while results
// are taken, one request per cycle; decode and shadow update are one stage.
// The output register lets a new request in while a result waits to be taken.
// Reset (synchronous, active high) clears all shadows, the address toggle,
// the queue count and both valid flags.
// ----------------------------------------------------------------------------
// PPU register write capture
// Decodes CPU bus writes into RAM, PPU register, VRAM queue, IO and debug
// results, keeping the PPU register shadows.
// ----------------------------------------------------------------------------
module ppu_register_write_capture_top #(
  parameter int unsigned QUEUE_ENTRIES = prwc_pkg::QueueEntriesDef
) (
  input  logic              clk,
  input  logic              rst,
  prwc_in_if.sink           in_ch,
  prwc_out_if.source        out_ch
);
  import prwc_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_ENTRIES) + 1;
  localparam logic [CntW-1:0] QueueLimit = CntW'(QUEUE_ENTRIES);

  // Input register.
  logic             in_valid;
  logic [AddrW-1:0] in_addr;
  logic [DataW-1:0] in_data;

  // Shadow state.
  logic [DataW-1:0] ctrl_shadow, ctrl_shadow_next;
  logic [DataW-1:0] mask_shadow, mask_shadow_next;
  logic [AddrW-1:0] vram_pointer, vram_pointer_next;
  logic [DataW-1:0] scroll_x_reg, scroll_x_next;
  logic [DataW-1:0] scroll_y_reg, scroll_y_next;
  logic             write_toggle, write_toggle_next;
  logic [CntW-1:0]  queued_entries, queued_entries_next;

  // Result of the decode stage.
  logic             res_valid;
  event_t           res_event;
  logic [AddrW-1:0] res_target;
  logic [DataW-1:0] res_data;
  logic             res_flush;
  logic [CntW-1:0]  count_inc;

  // Output register.
  logic             out_valid;
  event_t           out_event;
  logic [AddrW-1:0] out_target;
  logic [DataW-1:0] out_data;
  logic [DataW-1:0] out_scroll_x;
  logic [DataW-1:0] out_scroll_y;
  logic             out_flush;

  logic out_free;
  logic advance;

  // The output register is free when empty or being emptied this cycle.
  assign out_free    = !out_valid || out_ch.ready;
  assign advance     = in_valid && out_free;
  assign in_ch.ready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_addr <= in_ch.bus_address;
      in_data <= in_ch.write_data;
    end
  end

  // Decode and shadow update.
  always_comb begin
    ctrl_shadow_next    = ctrl_shadow;
    mask_shadow_next    = mask_shadow;
    vram_pointer_next   = vram_pointer;
    scroll_x_next       = scroll_x_reg;
    scroll_y_next       = scroll_y_reg;
    write_toggle_next   = write_toggle;
    queued_entries_next = queued_entries;
    res_valid           = 1'b0;
    res_event           = EV_RAM;
    res_target          = '0;
    res_data            = in_data;
    res_flush           = 1'b0;
    count_inc           = queued_entries + CntW'(1);

    if (in_addr[AddrW-1:AddrW-3] == 3'b000) begin
      // Work RAM and its mirrors.
      res_valid  = 1'b1;
      res_event  = EV_RAM;
      res_target = in_addr & RamMask;
    end else if (in_addr[AddrW-1:AddrW-3] == 3'b001) begin
      // PPU registers; mirrors above the first eight bytes are ignored.
      if (in_addr[AddrW-1:3] == PpuRegBase) begin
        unique case (ppu_reg_t'(in_addr[2:0]))
          REG_CTRL: begin
            ctrl_shadow_next = in_data;
            res_valid        = 1'b1;
            res_event        = EV_CTRL;
            res_data         = in_data | CtrlForce;
          end
          REG_MASK: begin
            mask_shadow_next = in_data;
            res_valid        = 1'b1;
            res_event        = EV_MASK;
          end
          REG_SCROLL: begin
            if (write_toggle) begin
              scroll_y_next = in_data;
            end else begin
              scroll_x_next = in_data;
            end
            write_toggle_next = !write_toggle;
            res_valid         = 1'b1;
            res_event         = EV_SCROLL;
          end
          REG_ADDR: begin
            if (write_toggle) begin
              vram_pointer_next = {vram_pointer[AddrW-1:DataW], in_data};
            end else begin
              vram_pointer_next = {in_data, vram_pointer[DataW-1:0]};
            end
            write_toggle_next = !write_toggle;
          end
          REG_DATA: begin
            vram_pointer_next = vram_pointer +
                                (ctrl_shadow[CtrlIncBit] ? StepWide : StepNarrow);
            res_valid  = 1'b1;
            res_event  = EV_VRAM;
            res_target = vram_pointer;
            if (count_inc >= QueueLimit) begin
              res_flush           = 1'b1;
              queued_entries_next = '0;
            end else begin
              queued_entries_next = count_inc;
            end
          end
          REG_STATUS, REG_OAMADR, REG_OAMDAT: begin
            res_valid = 1'b0;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end else if (in_addr[AddrW-1:AddrW-4] == 4'h4) begin
      // IO space passes through, except the DMA port.
      if (in_addr != DmaAddr) begin
        res_valid  = 1'b1;
        res_event  = EV_IO;
        res_target = in_addr;
      end
    end else if (!in_addr[AddrW-1]) begin
      // Debug slots.
      res_valid  = 1'b1;
      res_event  = EV_DEBUG;
      res_target = DebugBase + {{(AddrW-6){1'b0}}, in_addr[5:0]};
    end
  end

  // Shadow registers change only when a request leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_shadow    <= '0;
      mask_shadow    <= '0;
      vram_pointer   <= '0;
      scroll_x_reg   <= '0;
      scroll_y_reg   <= '0;
      write_toggle   <= 1'b0;
      queued_entries <= '0;
    end else if (advance) begin
      ctrl_shadow    <= ctrl_shadow_next;
      mask_shadow    <= mask_shadow_next;
      vram_pointer   <= vram_pointer_next;
      scroll_x_reg   <= scroll_x_next;
      scroll_y_reg   <= scroll_y_next;
      write_toggle   <= write_toggle_next;
      queued_entries <= queued_entries_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
    if (advance && res_valid) begin
      out_event    <= res_event;
      out_target   <= res_target;
      out_data     <= res_data;
      out_scroll_x <= scroll_x_next;
      out_scroll_y <= scroll_y_next;
      out_flush    <= res_flush;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.event_res   = out_event;
  assign out_ch.target      = out_target;
  assign out_ch.data_out    = out_data;
  assign out_ch.scroll_x    = out_scroll_x;
  assign out_ch.scroll_y    = out_scroll_y;
  assign out_ch.flush_after = out_flush;

endmodule

[sv/prwc_checker.sv]
// ----------------------------------------------------------------------------
// PPU register write capture: port checker
// Watches the result channel of the capture block over time.
// ----------------------------------------------------------------------------
module prwc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prwc_pkg::EventW-1:0] out_event,
  input logic [prwc_pkg::AddrW-1:0]  out_target,
  input logic [prwc_pkg::DataW-1:0]  out_data,
  input logic                        out_flush
);
  import prwc_pkg::*;

  // A result that is not taken stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // Only a VRAM entry may carry the flush flag.
  a_flush_vram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flush |-> out_event == EV_VRAM)
    else $error("flush flag on a result that is not a VRAM entry");

  // A control write always shows bit 7 set and no target.
  a_ctrl_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_CTRL |-> out_data[DataW-1] && out_target == '0)
    else $error("control result malformed");

  // Register shadow results carry no target.
  a_reg_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_event == EV_MASK || out_event == EV_SCROLL) |-> out_target == '0)
    else $error("mask or scroll result with a target");

endmodule

bind ppu_register_write_capture_top prwc_checker u_prwc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_event (out_ch.event_res),
  .out_target(out_ch.target),
  .out_data  (out_ch.data_out),
  .out_flush (out_ch.flush_after)
);
